[rtl/stok_pkg.sv]
// Shared types and constants for the source tokenizer.
`default_nettype none
package stok_pkg;

   localparam int MAX_SOURCE_LENGTH_DEF = 65536;
   localparam int QUEUE_DEPTH_DEF       = 4;
   localparam int MAX_RESULTS           = 3;
   localparam int IDX_W                 = $clog2(MAX_RESULTS);
   localparam int CNT_W                 = $clog2(MAX_RESULTS + 1);

   localparam logic [4:0] KIND_END       = 5'd0;
   localparam logic [4:0] KIND_IDENT     = 5'd1;
   localparam logic [4:0] KIND_INT       = 5'd2;
   localparam logic [4:0] KIND_FLOAT     = 5'd3;
   localparam logic [4:0] KIND_STRING    = 5'd4;
   localparam logic [4:0] KIND_NFUNC     = 5'd5;
   localparam logic [4:0] KIND_NTYPE     = 5'd6;
   localparam logic [4:0] KIND_SEMI      = 5'd7;
   localparam logic [4:0] KIND_PLUS      = 5'd8;
   localparam logic [4:0] KIND_MINUS     = 5'd9;
   localparam logic [4:0] KIND_STAR      = 5'd10;
   localparam logic [4:0] KIND_SLASH     = 5'd11;
   localparam logic [4:0] KIND_COMMA     = 5'd12;
   localparam logic [4:0] KIND_LPAREN    = 5'd13;
   localparam logic [4:0] KIND_RPAREN    = 5'd14;
   localparam logic [4:0] KIND_EQUALS    = 5'd15;
   localparam logic [4:0] KIND_LBRACE    = 5'd16;
   localparam logic [4:0] KIND_RBRACE    = 5'd17;
   localparam logic [4:0] KIND_BAD_UNDER = 5'd18;
   localparam logic [4:0] KIND_UNKNOWN   = 5'd19;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        err;
   } rec_type;

   typedef struct packed {
      logic [CNT_W-1:0]            count;
      rec_type [MAX_RESULTS-1:0]   recs;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage
`default_nettype wire

[rtl/stok_front.sv]
// Front end: takes source bytes, runs the lexer state and builds record bundles.
`default_nettype none
module stok_front #(
   parameter int MAX_SOURCE_LENGTH = stok_pkg::MAX_SOURCE_LENGTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,
   input  wire logic                req_tuser,
   input  wire logic                req_tlast,
   input  wire stok_pkg::q_stat_type q_status,
   output logic                     push,
   output stok_pkg::bundle_type     push_data
);
   import stok_pkg::*;

   localparam int          LIMIT_INT = (MAX_SOURCE_LENGTH - 1 > 65535) ? 65535
                                       : MAX_SOURCE_LENGTH - 1;
   localparam logic [15:0] PosLimit  = 16'(LIMIT_INT);

   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum logic [7:0] {
      MODE_IDLE   = 8'b0000_0001,
      MODE_IDENT  = 8'b0000_0010,
      MODE_INT    = 8'b0000_0100,
      MODE_FLOAT  = 8'b0000_1000,
      MODE_STRING = 8'b0001_0000,
      MODE_UNDER  = 8'b0010_0000,
      MODE_NFUNC  = 8'b0100_0000,
      MODE_NTYPE  = 8'b1000_0000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] start_ff, start_in;
   logic [2:0]  urun_ff, urun_in;
   logic        err_ff, err_in;

   logic        accept;
   logic [15:0] pos_inc;
   logic        st_emit;
   logic [4:0]  st_kind;
   mode_type    st_mode;
   logic [15:0] st_start;
   logic        st_err;
   bundle_type  bundle;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_name(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic [4:0] op_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h3B:   k = KIND_SEMI;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h2C:   k = KIND_COMMA;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h3D:   k = KIND_EQUALS;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] mode_kind(input mode_type m);
      logic [4:0] k;
      case (m)
         MODE_IDENT:  k = KIND_IDENT;
         MODE_INT:    k = KIND_INT;
         MODE_FLOAT:  k = KIND_FLOAT;
         MODE_STRING: k = KIND_STRING;
         MODE_NFUNC:  k = KIND_NFUNC;
         MODE_NTYPE:  k = KIND_NTYPE;
         default:     k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] span(input logic [15:0] pos, input logic [15:0] st);
      return (pos >= st) ? pos - st : 16'd0;
   endfunction

   function automatic rec_type make_rec(input logic [4:0] kind, input logic [15:0] start,
                                        input logic [15:0] length, input logic err);
      rec_type r;
      r.kind   = kind;
      r.start  = start;
      r.length = length;
      r.err    = err;
      return r;
   endfunction

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign pos_inc    = (position_ff < PosLimit) ? position_ff + 16'd1 : PosLimit;

   // what the byte does when no token is open
   always_comb begin
      st_emit  = 1'b0;
      st_kind  = KIND_UNKNOWN;
      st_mode  = MODE_IDLE;
      st_start = position_ff;
      st_err   = 1'b0;
      if (req_tdata == CH_UNDER) begin
         st_mode = MODE_UNDER;
      end else if (req_tdata == CH_QUOTE) begin
         st_mode  = MODE_STRING;
         st_start = pos_inc;
      end else if (op_kind(req_tdata) != KIND_UNKNOWN) begin
         st_emit = 1'b1;
         st_kind = op_kind(req_tdata);
      end else if (is_space(req_tdata)) begin
         st_mode = MODE_IDLE;
      end else if (is_alpha(req_tdata)) begin
         st_mode = MODE_IDENT;
      end else if (is_digit(req_tdata)) begin
         st_mode = MODE_INT;
      end else begin
         st_emit = 1'b1;
         st_err  = 1'b1;
      end
   end

   always_comb begin
      logic       do_start;
      logic [15:0] pos_v;
      logic [CNT_W-1:0] n;
      mode_type   m;
      logic [15:0] ts;
      logic [2:0] ur;
      logic       er;

      do_start = 1'b0;
      pos_v    = position_ff;
      n        = '0;
      m        = mode_ff;
      ts       = start_ff;
      ur       = urun_ff;
      er       = err_ff;
      bundle   = '0;

      if (req_tuser) begin
         case (mode_ff)
            MODE_IDLE: begin
               do_start = 1'b1;
            end
            MODE_IDENT, MODE_FLOAT: begin
               if (!(is_alpha(req_tdata) && mode_ff == MODE_IDENT) &&
                   !(is_digit(req_tdata) && mode_ff == MODE_FLOAT)) begin
                  bundle.recs[IDX_W'(n)] = make_rec(mode_kind(mode_ff), start_ff,
                                                    span(position_ff, start_ff), 1'b0);
                  n        = n + CNT_W'(1);
                  do_start = 1'b1;
               end
            end
            MODE_INT: begin
               if (req_tdata == CH_DOT) begin
                  m = MODE_FLOAT;
               end else if (!is_digit(req_tdata)) begin
                  bundle.recs[IDX_W'(n)] = make_rec(KIND_INT, start_ff,
                                                    span(position_ff, start_ff), 1'b0);
                  n        = n + CNT_W'(1);
                  do_start = 1'b1;
               end
            end
            MODE_STRING: begin
               if (req_tdata == CH_QUOTE) begin
                  bundle.recs[IDX_W'(n)] = make_rec(KIND_STRING, start_ff,
                                                    span(position_ff, start_ff), 1'b0);
                  n = n + CNT_W'(1);
                  m = MODE_IDLE;
               end
            end
            MODE_UNDER: begin
               if (req_tdata == CH_UNDER) begin
                  ur = (urun_ff < 3'd7) ? urun_ff + 3'd1 : urun_ff;
               end else if (urun_ff == 3'd2 || urun_ff == 3'd3) begin
                  if (is_name(req_tdata)) begin
                     m  = (urun_ff == 3'd2) ? MODE_NFUNC : MODE_NTYPE;
                     ts = position_ff;
                  end else begin
                     bundle.recs[IDX_W'(n)] = make_rec(
                        (urun_ff == 3'd2) ? KIND_NFUNC : KIND_NTYPE,
                        position_ff, 16'd0, 1'b0);
                     n        = n + CNT_W'(1);
                     do_start = 1'b1;
                  end
               end else begin
                  bundle.recs[IDX_W'(n)] = make_rec(KIND_BAD_UNDER, start_ff,
                                                    span(position_ff, start_ff), 1'b0);
                  n        = n + CNT_W'(1);
                  er       = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_NFUNC, MODE_NTYPE: begin
               if (!is_name(req_tdata)) begin
                  bundle.recs[IDX_W'(n)] = make_rec(mode_kind(mode_ff), start_ff,
                                                    span(position_ff, start_ff), 1'b0);
                  n        = n + CNT_W'(1);
                  do_start = 1'b1;
               end
            end
            default: begin
               m = MODE_IDLE;
            end
         endcase
         if (do_start) begin
            m  = st_mode;
            ts = st_start;
            ur = 3'd1;
            er = er | st_err;
            if (st_emit) begin
               bundle.recs[IDX_W'(n)] = make_rec(st_kind, position_ff, 16'd1, 1'b0);
               n = n + CNT_W'(1);
            end
         end
         pos_v = pos_inc;
      end

      mode_in     = m;
      position_in = pos_v;
      start_in    = ts;
      urun_in     = ur;
      err_in      = er;

      if (req_tlast) begin
         case (m)
            MODE_IDENT, MODE_INT, MODE_FLOAT, MODE_STRING, MODE_NFUNC, MODE_NTYPE: begin
               bundle.recs[IDX_W'(n)] = make_rec(mode_kind(m), ts, span(pos_v, ts), 1'b0);
               n = n + CNT_W'(1);
            end
            MODE_UNDER: begin
               if (ur == 3'd2 || ur == 3'd3) begin
                  bundle.recs[IDX_W'(n)] = make_rec((ur == 3'd2) ? KIND_NFUNC : KIND_NTYPE,
                                                    pos_v, 16'd0, 1'b0);
               end else begin
                  bundle.recs[IDX_W'(n)] = make_rec(KIND_BAD_UNDER, ts, span(pos_v, ts), 1'b0);
                  er = 1'b1;
               end
               n = n + CNT_W'(1);
            end
            default: begin
               n = n;
            end
         endcase
         bundle.recs[IDX_W'(n)] = make_rec(KIND_END, pos_v, 16'd0, er);
         n           = n + CNT_W'(1);
         mode_in     = MODE_IDLE;
         position_in = 16'd0;
         start_in    = 16'd0;
         urun_in     = 3'd0;
         err_in      = 1'b0;
      end
      bundle.count = n;
   end

   assign push      = accept && (bundle.count != '0);
   assign push_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         position_ff <= 16'd0;
         start_ff    <= 16'd0;
         urun_ff     <= 3'd0;
         err_ff      <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         start_ff    <= start_in;
         urun_ff     <= urun_in;
         err_ff      <= err_in;
      end
   end

endmodule
`default_nettype wire

[rtl/stok_queue.sv]
// Short queue of record bundles between the front and back ends.
`default_nettype none
module stok_queue #(
   parameter int DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire stok_pkg::bundle_type push_data,
   input  wire logic                 pop,
   output stok_pkg::bundle_type      head_data,
   output stok_pkg::q_stat_type      status
);
   import stok_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   bundle_type           store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign status.full  = (count_ff == CNT_W_Q'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/stok_back.sv]
// Back end: unpacks bundles into single token records on the result channel.
`default_nettype none
module stok_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire stok_pkg::q_stat_type q_status,
   input  wire stok_pkg::bundle_type head_data,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,  // start[15:0], length[31:16], error[32], pad
   output logic [4:0]                rsp_tuser,  // token kind
   output logic                      rsp_tlast
);
   import stok_pkg::*;

   logic             valid_ff, valid_in;
   rec_type          rec_ff, rec_in;
   logic             last_ff, last_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             load, is_last;

   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign is_last = (CNT_W'(idx_ff) + CNT_W'(1)) == head_data.count;
   assign pop     = load && is_last;

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         rec_in   = head_data.recs[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? '0 : idx_ff + IDX_W'(1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, rec_ff.err, rec_ff.length, rec_ff.start};
   assign rsp_tuser  = rec_ff.kind;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

[rtl/source_tokenizer.sv]
// Source tokenizer top level: byte stream in, token records out.
// The first record of a byte passes the queue and then the registered output stage before it can be taken.
// One byte per cycle while the queue is not full and each byte gives at most one record; a byte giving
// several records (up to three) sends them in turn on the result channel, the queue absorbing bursts.
// Synchronous reset clears the lexer state, the queue and the output stage.
`default_nettype none
module source_tokenizer #(
   parameter int MAX_SOURCE_LENGTH = stok_pkg::MAX_SOURCE_LENGTH_DEF,
   parameter int QUEUE_DEPTH       = stok_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // ch[7:0]
   input  wire logic        req_tuser,   // char_valid
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // lexeme_start[15:0], lexeme_length[31:16], error_seen[32]
   output logic [4:0]       rsp_tuser,   // token_kind[4:0]
   output logic             rsp_tlast    // last_of_run
);
   import stok_pkg::*;

   q_stat_type q_status;
   bundle_type push_data, head_data;
   logic       push, pop;

   stok_front #(
      .MAX_SOURCE_LENGTH(MAX_SOURCE_LENGTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   stok_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (q_status)
   );

   stok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire
